>>> hw/rtl/irp_pkg.sv
// ============================================================================
// irp_pkg
// Shared types and constants of the directory record parser.
// ============================================================================
package irp_pkg;

    // Record layout, as byte offsets within one directory record
    localparam logic [8:0] POS_LEN      = 9'd0;
    localparam logic [8:0] POS_EXT_LO   = 9'd2;
    localparam logic [8:0] POS_EXT_HI   = 9'd5;
    localparam logic [8:0] POS_SIZE_LO  = 9'd10;
    localparam logic [8:0] POS_SIZE_HI  = 9'd13;
    localparam logic [8:0] POS_FLAGS    = 9'd25;
    localparam logic [8:0] POS_NAME_LEN = 9'd32;
    localparam logic [8:0] HDR_BYTES    = 9'd33;

    // Name characters of interest
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // Longest name kept, so the trimmed length fits in seven bits
    localparam int NAME_MAX = 127;

    // Entries in flight between parser and emitter (one name bank each)
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_CHUNK  = 1'b1;

    // Parsed entry, ready for emission
    typedef struct packed {
        logic [31:0] extent;
        logic [31:0] size;
        logic [7:0]  flags;
        logic [6:0]  tlen;
    } irp_desc_t;

    // One name byte write from the parser into the name banks
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [6:0] index;
        logic [7:0] data;
    } irp_nwr_t;

    // Queue tail status seen by the parser
    typedef struct packed {
        logic ready;
        logic bank;
    } irp_qtail_t;

    // Queue head seen by the emitter
    typedef struct packed {
        logic      valid;
        logic      bank;
        irp_desc_t desc;
    } irp_qhead_t;

endpackage

>>> hw/rtl/iso9660_directory_record_parser_core.sv
// ============================================================================
// iso9660_directory_record_parser_core
// Parses directory records from a byte stream into entry headers and
// eight-byte name chunks.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one directory byte per request,
//   with end_of_extent set on the last byte of the extent; the parser
//   returns to sector and record start after that byte.
//   Output channel (out_valid / out_stall): per record, one header result
//   then ceil(trimmed_length / 8) name chunk results; last_of_entry marks
//   the final one. Dot entries give no results.
// Throughput: one byte per cycle while in_stall is low; the emitter sends one
//   result per cycle while out_stall is low. A header passes the queue slot and
//   output register after its final byte is accepted; chunks follow one per cycle.
// The two-entry queue between parser and emitter, each entry owning one
//   name bank, sets when in_stall rises: with two finished entries still
//   waiting, the input stalls until the emitter retires one.
// A stalled output holds its result; the emitter and queue keep their place.
// Reset clears positions, queue and output valid; name banks keep old data.
// ============================================================================
module iso9660_directory_record_parser_core #(
    parameter int SECTOR_BYTES = 2048,
    parameter int NAME_LIMIT   = 127
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_extent,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [31:0] extent_lba,
    output logic [31:0] file_size,
    output logic [7:0]  entry_flags,
    output logic [6:0]  trimmed_length,
    output logic [63:0] name_chunk,
    output logic        last_of_entry
);
    import irp_pkg::*;

    localparam int NameCap  = (NAME_LIMIT < NAME_MAX) ? NAME_LIMIT : NAME_MAX;
    localparam int NameRows = (NameCap + 7) / 8;

    irp_qtail_t tail;
    irp_qhead_t head;
    irp_desc_t  push_desc;
    irp_nwr_t   nwr;
    logic       push, pop;

    irp_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .NAME_CAP     (NameCap)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_extent (end_of_extent),
        .tail          (tail),
        .push          (push),
        .push_desc     (push_desc),
        .nwr           (nwr)
    );

    irp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .tail      (tail),
        .head      (head)
    );

    irp_back #(
        .NAME_ROWS (NameRows)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .nwr            (nwr),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .extent_lba     (extent_lba),
        .file_size      (file_size),
        .entry_flags    (entry_flags),
        .trimmed_length (trimmed_length),
        .name_chunk     (name_chunk),
        .last_of_entry  (last_of_entry)
    );

endmodule

>>> hw/rtl/irp_front.sv
// ============================================================================
// irp_front
// Byte parser: tracks sector and record position, collects header fields,
// writes name bytes and pushes one trimmed entry per finished record.
// ============================================================================
module irp_front #(
    parameter int SECTOR_BYTES = 2048,
    parameter int NAME_CAP     = 127
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_extent,
    input  irp_pkg::irp_qtail_t   tail,
    output logic                  push,
    output irp_pkg::irp_desc_t    push_desc,
    output irp_pkg::irp_nwr_t     nwr
);
    import irp_pkg::*;

    localparam int         SpW    = $clog2(SECTOR_BYTES);
    localparam logic [SpW:0] SecEnd = (SpW + 1)'(SECTOR_BYTES);
    localparam logic [7:0] Cap8   = 8'(NAME_CAP);

    // Control state
    logic [SpW-1:0] sect_pos_reg, sect_pos_next;
    logic           skip_reg, skip_next;
    logic [8:0]     rec_pos_reg, rec_pos_next;
    logic           nul_seen_reg, nul_seen_next;
    logic           semi_seen_reg, semi_seen_next;

    // Record payload
    logic [7:0]  rec_len_reg, rec_len_next;
    logic [7:0]  raw_len_reg, raw_len_next;
    logic [31:0] ext_reg, ext_next;
    logic [31:0] size_reg, size_next;
    logic [7:0]  flags_reg, flags_next;
    logic [6:0]  nul_idx_reg, nul_idx_next;
    logic [6:0]  semi_idx_reg, semi_idx_next;
    logic [7:0]  byte0_reg, byte0_next;
    logic [7:0]  last_byte_reg, last_byte_next;
    logic [7:0]  pre_nul_reg, pre_nul_next;
    logic [7:0]  pre_semi_reg, pre_semi_next;

    logic         acc, take, emit, wrapped, drop, nul_seen_upd, semi_seen_upd;
    logic [SpW:0] sp_inc;
    logic [7:0]   name_idx, raw_len_cur;
    logic [8:0]   hdr_end, end_pos;
    logic [1:0]   bsel;
    logic [6:0]   lim, tlen;
    logic [7:0]   ch;

    assign in_stall = !tail.ready;

    // Next state of the parser
    always_comb
    begin
        acc            = in_valid && tail.ready;
        sp_inc         = {1'b0, sect_pos_reg} + 1'b1;
        wrapped        = (sp_inc == SecEnd);
        sect_pos_next  = sect_pos_reg;
        skip_next      = skip_reg;
        rec_pos_next   = rec_pos_reg;
        take           = 1'b0;
        emit           = 1'b0;
        nul_seen_upd   = nul_seen_reg;
        semi_seen_upd  = semi_seen_reg;
        rec_len_next   = rec_len_reg;
        raw_len_next   = raw_len_reg;
        ext_next       = ext_reg;
        size_next      = size_reg;
        flags_next     = flags_reg;
        nul_idx_next   = nul_idx_reg;
        semi_idx_next  = semi_idx_reg;
        byte0_next     = byte0_reg;
        last_byte_next = last_byte_reg;
        pre_nul_next   = pre_nul_reg;
        pre_semi_next  = pre_semi_reg;
        nwr            = '0;
        nwr.bank       = tail.bank;
        name_idx       = 8'(rec_pos_reg - HDR_BYTES);
        bsel           = rec_pos_reg[1:0] - 2'd2;
        raw_len_cur    = (rec_pos_reg == POS_NAME_LEN) ? data_byte : raw_len_reg;
        hdr_end        = HDR_BYTES + {1'b0, raw_len_cur};
        end_pos        = (hdr_end > {1'b0, rec_len_reg}) ? hdr_end : {1'b0, rec_len_reg};

        // sector position and padding skip
        if (acc)
        begin
            sect_pos_next = wrapped ? '0 : sp_inc[SpW-1:0];
            if (skip_reg)
            begin
                if (wrapped)
                    skip_next = 1'b0;
            end
            else if (rec_pos_reg == POS_LEN && data_byte == 8'h00)
            begin
                if (!wrapped)
                    skip_next = 1'b1;
            end
            else
                take = 1'b1;
        end

        // record fields
        if (take)
        begin
            if (rec_pos_reg == POS_LEN)
                rec_len_next = data_byte;
            else if (rec_pos_reg inside {[POS_EXT_LO:POS_EXT_HI]})
                ext_next[{bsel, 3'b000} +: 8] = data_byte;
            else if (rec_pos_reg inside {[POS_SIZE_LO:POS_SIZE_HI]})
                size_next[{bsel, 3'b000} +: 8] = data_byte;
            else if (rec_pos_reg == POS_FLAGS)
                flags_next = data_byte;
            else if (rec_pos_reg == POS_NAME_LEN)
                raw_len_next = data_byte;
            else if (rec_pos_reg >= HDR_BYTES && name_idx < raw_len_reg && name_idx < Cap8)
            begin
                nwr.en         = 1'b1;
                nwr.index      = name_idx[6:0];
                nwr.data       = data_byte;
                last_byte_next = data_byte;
                if (name_idx == 8'd0)
                    byte0_next = data_byte;
                if (data_byte == 8'h00 && !nul_seen_reg)
                begin
                    nul_seen_upd = 1'b1;
                    nul_idx_next = name_idx[6:0];
                    pre_nul_next = last_byte_reg;
                end
                if (data_byte == CH_SEMI)
                begin
                    semi_seen_upd = 1'b1;
                    semi_idx_next = name_idx[6:0];
                    pre_semi_next = last_byte_reg;
                end
            end

            // end of record: header and name both taken, length reached
            if (rec_pos_reg >= POS_NAME_LEN && rec_pos_reg + 9'd1 >= end_pos)
                emit = 1'b1;
            else
                rec_pos_next = rec_pos_reg + 9'd1;
        end

        // name trim: cap, first NUL, last ';', one trailing '.'
        lim = (raw_len_next > Cap8) ? Cap8[6:0] : raw_len_next[6:0];
        ch  = last_byte_next;
        if (nul_seen_upd && nul_idx_next < lim)
        begin
            lim = nul_idx_next;
            ch  = pre_nul_next;
        end
        if (semi_seen_upd && semi_idx_next < lim)
        begin
            lim = semi_idx_next;
            ch  = pre_semi_next;
        end
        tlen = (lim != 7'd0 && ch == CH_DOT) ? lim - 7'd1 : lim;

        // dot and dot-dot entries give nothing
        drop = (raw_len_next == 8'd1) && (byte0_next == 8'd0 || byte0_next == 8'd1);

        push             = emit && !drop;
        push_desc.extent = ext_next;
        push_desc.size   = size_next;
        push_desc.flags  = flags_next;
        push_desc.tlen   = tlen;

        nul_seen_next  = nul_seen_upd;
        semi_seen_next = semi_seen_upd;
        if (emit || (acc && end_of_extent))
        begin
            rec_pos_next   = '0;
            nul_seen_next  = 1'b0;
            semi_seen_next = 1'b0;
        end
        if (acc && end_of_extent)
        begin
            sect_pos_next = '0;
            skip_next     = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sect_pos_reg  <= '0;
            skip_reg      <= 1'b0;
            rec_pos_reg   <= '0;
            nul_seen_reg  <= 1'b0;
            semi_seen_reg <= 1'b0;
        end
        else
        begin
            sect_pos_reg  <= sect_pos_next;
            skip_reg      <= skip_next;
            rec_pos_reg   <= rec_pos_next;
            nul_seen_reg  <= nul_seen_next;
            semi_seen_reg <= semi_seen_next;
        end
    end

    // Payload registers, always rewritten before use
    always_ff @(posedge clk)
    begin
        rec_len_reg   <= rec_len_next;
        raw_len_reg   <= raw_len_next;
        ext_reg       <= ext_next;
        size_reg      <= size_next;
        flags_reg     <= flags_next;
        nul_idx_reg   <= nul_idx_next;
        semi_idx_reg  <= semi_idx_next;
        byte0_reg     <= byte0_next;
        last_byte_reg <= last_byte_next;
        pre_nul_reg   <= pre_nul_next;
        pre_semi_reg  <= pre_semi_next;
    end

endmodule

>>> hw/rtl/irp_queue.sv
// ============================================================================
// irp_queue
// Two-entry queue of parsed entries; slot number doubles as name bank.
// ============================================================================
module irp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  irp_pkg::irp_desc_t  push_desc,
    input  logic                pop,
    output irp_pkg::irp_qtail_t tail,
    output irp_pkg::irp_qhead_t head
);
    import irp_pkg::*;

    irp_desc_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign tail.ready = (cnt_reg != QUEUE_DEPTH);
    assign tail.bank  = wr_ptr_reg;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.bank  = rd_ptr_reg;
    assign head.desc  = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

>>> hw/rtl/irp_back.sv
// ============================================================================
// irp_back
// Emitter: holds the two name banks and sends a header then the name
// chunks of the queue head through the output register.
// ============================================================================
module irp_back #(
    parameter int NAME_ROWS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  irp_pkg::irp_nwr_t   nwr,
    input  irp_pkg::irp_qhead_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                item_kind,
    output logic [31:0]         extent_lba,
    output logic [31:0]         file_size,
    output logic [7:0]          entry_flags,
    output logic [6:0]          trimmed_length,
    output logic [63:0]         name_chunk,
    output logic                last_of_entry
);
    import irp_pkg::*;

    localparam int RowW     = (NAME_ROWS > 1) ? $clog2(NAME_ROWS) : 1;
    localparam int AddrW    = RowW + 1;
    localparam int MemDepth = 1 << AddrW;

    typedef enum logic {S_HDR, S_CHK} state_t;

    // Name banks: eight byte lanes, one row per chunk
    logic [7:0] name_mem [8][MemDepth];
    logic [7:0] rd_q [8];

    state_t          state_reg;
    logic [RowW-1:0] c_reg;
    logic            out_valid_reg, kind_reg, last_reg;
    logic [31:0]     ext_reg, size_reg;
    logic [7:0]      flags_reg, mask_reg;
    logic [6:0]      len_reg;

    logic             advance, hdr_last, chunk_last, rd_en;
    logic [7:0]       base, mask_c;
    logic [AddrW-1:0] waddr, raddr;

    // Issue control
    always_comb
    begin
        advance    = !out_valid_reg || !out_stall;
        base       = 8'({c_reg, 3'b000});
        hdr_last   = (head.desc.tlen == 7'd0);
        chunk_last = (base + 8'd8) >= {1'b0, head.desc.tlen};
        for (int j = 0; j < 8; j++)
            mask_c[j] = (base + 8'(j)) < {1'b0, head.desc.tlen};
        rd_en = advance && head.valid && (state_reg == S_CHK);
        raddr = {head.bank, c_reg};
        waddr = {nwr.bank, nwr.index[3 +: RowW]};
        pop   = advance && head.valid &&
                ((state_reg == S_HDR && hdr_last) || (state_reg == S_CHK && chunk_last));
    end

    // Name bank write and chunk read
    always_ff @(posedge clk)
    begin
        if (nwr.en)
            name_mem[nwr.index[2:0]][waddr] <= nwr.data;
        if (rd_en)
            for (int j = 0; j < 8; j++)
                rd_q[j] <= name_mem[j][raddr];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_HDR;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_HEADER;
            last_reg      <= 1'b0;
            ext_reg       <= '0;
            size_reg      <= '0;
            flags_reg     <= '0;
            len_reg       <= '0;
            mask_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= head.valid;
            if (head.valid)
            begin
                case (state_reg)
                    S_HDR:
                    begin
                        kind_reg  <= KIND_HEADER;
                        ext_reg   <= head.desc.extent;
                        size_reg  <= head.desc.size;
                        flags_reg <= head.desc.flags;
                        len_reg   <= head.desc.tlen;
                        mask_reg  <= '0;
                        last_reg  <= hdr_last;
                        c_reg     <= '0;
                        if (!hdr_last)
                            state_reg <= S_CHK;
                    end
                    S_CHK:
                    begin
                        kind_reg  <= KIND_CHUNK;
                        ext_reg   <= '0;
                        size_reg  <= '0;
                        flags_reg <= '0;
                        len_reg   <= '0;
                        mask_reg  <= mask_c;
                        last_reg  <= chunk_last;
                        if (chunk_last)
                            state_reg <= S_HDR;
                        else
                            c_reg <= c_reg + 1'b1;
                    end
                    default:
                        state_reg <= S_HDR;
                endcase
            end
        end
    end

    // Output payload; bytes past the name read as zero
    always_comb
    begin
        for (int j = 0; j < 8; j++)
            name_chunk[8*j +: 8] = mask_reg[j] ? rd_q[j] : 8'h00;
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = kind_reg;
    assign extent_lba     = ext_reg;
    assign file_size      = size_reg;
    assign entry_flags    = flags_reg;
    assign trimmed_length = len_reg;
    assign last_of_entry  = last_reg;

endmodule

>>> tb/iso9660_directory_record_parser_core_test.sv
// ============================================================================
// iso9660_directory_record_parser_core_test
// Streams directory extent bytes into the record parser and checks every
// header and name chunk result against an in-bench model of the parser.
// Directed records cover dot entries, name trimming, short and padded
// records, sector skips and extent ends. Random records follow under four
// idle and stall mixes on the two channels.
// ============================================================================
module iso9660_directory_record_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import irp_pkg::*;

    localparam int SECTOR_BYTES = 2048;
    localparam int NAME_LIMIT   = 127;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    // One result as seen on the output channel
    typedef struct packed {
        logic        kind;
        logic [31:0] extent;
        logic [31:0] size;
        logic [7:0]  flags;
        logic [6:0]  tlen;
        logic [63:0] chunk;
        logic        last;
    } dir_result_t;

    // ------------------------------------------------------------------------
    // Entry scoreboard: mirrors the parser state and holds expected results
    // ------------------------------------------------------------------------
    class dir_entry_scoreboard;
        dir_result_t expected_results[$];
        int          mismatches;
        int          checked;
        int          predicted;
        int          sect_pos;
        int          rec_pos;
        int          nul_idx;
        int          semi_idx;
        bit          nul_seen;
        bit          semi_seen;
        bit          skipping;
        logic [7:0]  rec_len;
        logic [7:0]  name_len;
        logic [7:0]  flags_q;
        logic [31:0] extent_q;
        logic [31:0] size_q;
        logic [7:0]  name_bytes [128];

        function new();
            mismatches = 0;
            checked    = 0;
            predicted  = 0;
            sect_pos   = 0;
            skipping   = 1'b0;
            foreach (name_bytes[i])
                name_bytes[i] = 8'h00;
            clear_record();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void clear_record();
            rec_pos   = 0;
            rec_len   = 8'h00;
            name_len  = 8'h00;
            extent_q  = 32'h0;
            size_q    = 32'h0;
            flags_q   = 8'h00;
            nul_idx   = 0;
            nul_seen  = 1'b0;
            semi_idx  = 0;
            semi_seen = 1'b0;
        endfunction

        // Trim the name and queue the header plus its name chunks
        function void finish_entry();
            int          tl;
            int          n_chunks;
            dir_result_t r;
            // dot and dot-dot entries
            if (name_len == 8'd1 && name_bytes[0] <= 8'h01)
                return;
            tl = (name_len > NAME_MAX) ? NAME_MAX : int'(name_len);
            if (nul_seen && nul_idx < tl)
                tl = nul_idx;
            if (semi_seen && semi_idx < tl)
                tl = semi_idx;
            if (tl > 0 && name_bytes[tl - 1] == CH_DOT)
                tl--;
            n_chunks = (tl + 7) / 8;
            r        = '0;
            r.kind   = KIND_HEADER;
            r.extent = extent_q;
            r.size   = size_q;
            r.flags  = flags_q;
            r.tlen   = tl[6:0];
            r.last   = (n_chunks == 0);
            expected_results.push_back(r);
            for (int c = 0; c < n_chunks; c++)
            begin
                r      = '0;
                r.kind = KIND_CHUNK;
                for (int j = 0; j < 8; j++)
                    if (c * 8 + j < tl)
                        r.chunk[8 * j +: 8] = name_bytes[c * 8 + j];
                r.last = (c == n_chunks - 1);
                expected_results.push_back(r);
            end
            predicted += n_chunks + 1;
        endfunction

        // One byte inside a record
        function void take_byte(logic [7:0] b);
            int pos;
            int idx;
            int rec_end;
            pos = rec_pos;
            if (pos == POS_LEN)
                rec_len = b;
            else if (pos >= POS_EXT_LO && pos <= POS_EXT_HI)
                extent_q[8 * (pos - int'(POS_EXT_LO)) +: 8] = b;
            else if (pos >= POS_SIZE_LO && pos <= POS_SIZE_HI)
                size_q[8 * (pos - int'(POS_SIZE_LO)) +: 8] = b;
            else if (pos == POS_FLAGS)
                flags_q = b;
            else if (pos == POS_NAME_LEN)
                name_len = b;
            else if (pos >= HDR_BYTES)
            begin
                idx = pos - int'(HDR_BYTES);
                if (idx < int'(name_len) && idx < NAME_MAX)
                begin
                    name_bytes[idx] = b;
                    if (b == 8'h00 && !nul_seen)
                    begin
                        nul_seen = 1'b1;
                        nul_idx  = idx;
                    end
                    if (b == CH_SEMI)
                    begin
                        semi_seen = 1'b1;
                        semi_idx  = idx;
                    end
                end
            end
            // a record ends at its length byte or after its name, whichever is later
            if (pos >= POS_NAME_LEN)
            begin
                rec_end = int'(HDR_BYTES) + int'(name_len);
                if (int'(rec_len) > rec_end)
                    rec_end = int'(rec_len);
                if (pos + 1 >= rec_end)
                begin
                    finish_entry();
                    clear_record();
                    return;
                end
            end
            rec_pos = pos + 1;
        endfunction

        // Accepted input request
        function void note_request(logic [7:0] b, logic eoe);
            bit wrapped;
            sect_pos++;
            wrapped = (sect_pos >= SECTOR_BYTES);
            if (wrapped)
                sect_pos = 0;
            if (skipping)
            begin
                if (wrapped)
                    skipping = 1'b0;
            end
            else if (rec_pos == 0 && b == 8'h00)
            begin
                if (!wrapped)
                    skipping = 1'b1;
            end
            else
                take_byte(b);
            if (eoe)
            begin
                clear_record();
                sect_pos = 0;
                skipping = 1'b0;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        // Accepted output result against the oldest expectation
        task check_result(dir_result_t got);
            dir_result_t want;
            string       bad;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            bad = "";
            if (got.kind !== want.kind)
                bad = {bad, " item_kind"};
            if (got.extent !== want.extent)
                bad = {bad, " extent_lba"};
            if (got.size !== want.size)
                bad = {bad, " file_size"};
            if (got.flags !== want.flags)
                bad = {bad, " entry_flags"};
            if (got.tlen !== want.tlen)
                bad = {bad, " trimmed_length"};
            if (got.chunk !== want.chunk)
                bad = {bad, " name_chunk"};
            if (got.last !== want.last)
                bad = {bad, " last_of_entry"};
            if (bad != "")
                report($sformatf("result %0d wrong%s: got %h want %h", checked, bad, got,
                                 want));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and bench state
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte     = 8'h00;
    logic        end_of_extent = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        item_kind;
    logic [31:0] extent_lba;
    logic [31:0] file_size;
    logic [7:0]  entry_flags;
    logic [6:0]  trimmed_length;
    logic [63:0] name_chunk;
    logic        last_of_entry;

    dir_entry_scoreboard sb;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent     = 0;
    int         records_sent   = 0;
    int         skips          = 0;
    int         extents_closed = 0;
    int         sect_idx       = 0;
    int         quiet_cycles   = 0;
    logic [7:0] name_buf[$];

    iso9660_directory_record_parser_core #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .NAME_LIMIT   (NAME_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_extent  (end_of_extent),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .extent_lba     (extent_lba),
        .file_size      (file_size),
        .entry_flags    (entry_flags),
        .trimmed_length (trimmed_length),
        .name_chunk     (name_chunk),
        .last_of_entry  (last_of_entry)
    );

    always #6 clk = ~clk;

    // Receiver backpressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(dir_result_t'({item_kind, extent_lba, file_size, entry_flags,
                                           trimmed_length, name_chunk, last_of_entry}));
    end

    // Watchdog: cycles with neither a request nor a result moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One directory byte, with random sender gaps
    task automatic put_byte(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_extent <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(b, e);
        bytes_sent++;
        if (e)
            extents_closed++;
        sect_idx = e ? 0 : (sect_idx + 1) % SECTOR_BYTES;
    endtask

    // One record; cut_at > 0 stops early, eoe marks the last byte sent
    task automatic put_record(input logic [31:0] ext, input logic [31:0] size,
                              input logic [7:0] flags, input int len_byte,
                              input int raw_len, input int cut_at, input logic eoe);
        int         total;
        int         idx;
        logic [7:0] b;
        total = int'(HDR_BYTES) + raw_len;
        if (len_byte > total)
            total = len_byte;
        if (cut_at > 0 && cut_at < total)
            total = cut_at;
        for (int pos = 0; pos < total; pos++)
        begin
            b = 8'($urandom_range(0, 255));
            if (pos == POS_LEN)
                b = 8'(len_byte);
            else if (pos >= POS_EXT_LO && pos <= POS_EXT_HI)
                b = ext[8 * (pos - 2) +: 8];
            else if (pos >= 6 && pos <= 9)
                b = ext[8 * (9 - pos) +: 8];
            else if (pos >= POS_SIZE_LO && pos <= POS_SIZE_HI)
                b = size[8 * (pos - 10) +: 8];
            else if (pos >= 14 && pos <= 17)
                b = size[8 * (17 - pos) +: 8];
            else if (pos == POS_FLAGS)
                b = flags;
            else if (pos == POS_NAME_LEN)
                b = 8'(raw_len);
            else if (pos >= HDR_BYTES)
            begin
                idx = pos - int'(HDR_BYTES);
                if (idx < raw_len && idx < name_buf.size())
                    b = name_buf[idx];
            end
            put_byte(b, eoe && pos == total - 1);
        end
        records_sent++;
    endtask

    // Zero length byte, then filler to the sector end; cut ends the extent early
    task automatic put_skip(input bit cut);
        int left;
        put_byte(8'h00, 1'b0);
        left = cut ? $urandom_range(1, 64) : -1;
        while (sect_idx != 0)
        begin
            left--;
            put_byte(8'($urandom_range(0, 255)), left == 0);
        end
        skips++;
    endtask

    function automatic void load_name(input string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endfunction

    // Random name; plain names hold only capital letters
    function automatic void fill_name(input int n, input bit plain);
        int k;
        name_buf.delete();
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (plain)
                name_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
            else if (k < 78)
                name_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            else if (k < 86)
                name_buf.push_back(CH_DOT);
            else if (k < 92)
                name_buf.push_back(CH_SEMI);
            else if (k < 95)
                name_buf.push_back(8'h00);
            else
                name_buf.push_back(8'($urandom_range(0, 255)));
        end
        // usual version suffix
        if (!plain && n >= 3 && $urandom_range(1) == 1)
        begin
            name_buf[n - 2] = CH_SEMI;
            name_buf[n - 1] = 8'h31;
        end
    endfunction

    function automatic int pick_name_len();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(0, 24);
        if (k < 90)
            return $urandom_range(25, 127);
        return $urandom_range(128, 255);
    endfunction

    task automatic put_entry(input int n, input logic eoe);
        int len_byte;
        fill_name(n, 1'b0);
        len_byte = int'(HDR_BYTES) + n + $urandom_range(0, 3);
        if (len_byte > 255)
            len_byte = 255;
        put_record($urandom, $urandom, 8'($urandom_range(0, 255)), len_byte, n, 0, eoe);
    endtask

    // ------------------------------------------------------------------------
    // Directed records
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // dot and dot-dot give nothing; a one-byte name of value two does
        name_buf = {8'h00};
        put_record(32'h0000_0014, 32'h0000_0800, 8'h02, 34, 1, 0, 1'b0);
        name_buf = {8'h01};
        put_record(32'h0000_0013, 32'h0000_0800, 8'h02, 34, 1, 0, 1'b0);
        name_buf = {8'h02};
        put_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 34, 1, 0, 1'b0);

        // version suffix and trailing dot trimming, header fields at zero
        load_name("FILE.TXT;1");
        put_record(32'h0, 32'h0, 8'h00, 43, 10, 0, 1'b0);
        load_name("README.;1");
        put_record(32'h0000_1234, 32'h0000_0042, 8'h00, 42, 9, 0, 1'b0);
        load_name("A;B;C");
        put_record(32'h0000_0100, 32'h0000_0005, 8'h01, 38, 5, 0, 1'b0);
        load_name("X..");
        put_record(32'h8000_0000, 32'h0000_0001, 8'h80, 36, 3, 0, 1'b0);
        load_name(".");
        put_record(32'h0000_0001, 32'h8000_0000, 8'h04, 34, 1, 0, 1'b0);

        // NUL inside, NUL first, and semicolon ahead of a NUL
        load_name("ABXCD");
        name_buf[2] = 8'h00;
        put_record(32'h0000_0020, 32'h0000_0300, 8'h00, 38, 5, 0, 1'b0);
        load_name("QRS");
        name_buf[0] = 8'h00;
        put_record(32'h0000_0021, 32'h0000_0301, 8'h00, 36, 3, 0, 1'b0);
        load_name("AB;CXD");
        name_buf[4] = 8'h00;
        put_record(32'h0000_0022, 32'h0000_0302, 8'h00, 39, 6, 0, 1'b0);

        // empty name gives a lone header
        put_record(32'h0000_0030, 32'h0000_0000, 8'h02, 33, 0, 0, 1'b0);

        // longest kept name, an over-long one, and a dot right at the cap
        fill_name(127, 1'b1);
        put_record(32'h0000_0040, 32'h0001_0000, 8'h00, 160, 127, 0, 1'b0);
        fill_name(255, 1'b1);
        put_record(32'h0000_0041, 32'h0001_0001, 8'h00, 255, 255, 0, 1'b0);
        fill_name(128, 1'b1);
        name_buf[126] = CH_DOT;
        put_record(32'h0000_0042, 32'h0001_0002, 8'h00, 161, 128, 0, 1'b0);

        // padding beyond the name is ignored; a short length byte is repaired
        load_name("PAD");
        put_record(32'h0000_0050, 32'h0000_0010, 8'h00, 200, 3, 0, 1'b0);
        load_name("SHORTNAME.DAT;1");
        put_record(32'h0000_0051, 32'h0000_0011, 8'h00, 40, 15, 0, 1'b0);

        // zero length byte mid-sector
        put_skip(1'b0);

        // fill the next sector exactly so a zero lands on its last byte
        for (int i = 0; i < 7; i++)
        begin
            fill_name(20, 1'b1);
            put_record($urandom, $urandom, 8'h00, 255, 20, 0, 1'b0);
        end
        fill_name(10, 1'b1);
        put_record($urandom, $urandom, 8'h02, 229, 10, 0, 1'b0);
        put_record($urandom, $urandom, 8'h00, 33, 0, 0, 1'b0);
        put_byte(8'h00, 1'b0);

        // open record cut by the extent end, then an extent end on a record end
        load_name("CUT");
        put_record(32'h0000_0060, 32'h0000_0060, 8'h00, 36, 3, 20, 1'b1);
        load_name("LAST.;1");
        put_record(32'h0000_0061, 32'h0000_0061, 8'h00, 40, 7, 0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random records: mostly well formed, some short, cut or skipped
    // ------------------------------------------------------------------------
    task automatic run_random(input int want_results);
        int start_results;
        int start_bytes;
        int k;
        int n;
        start_results = sb.predicted;
        start_bytes   = bytes_sent;
        while (sb.predicted - start_results < want_results || bytes_sent - start_bytes < 40)
        begin
            k = $urandom_range(99);
            n = pick_name_len();
            if (k < 58)
                put_entry(n, 1'b0);
            else if (k < 68)
            begin
                name_buf.delete();
                name_buf.push_back(8'($urandom_range(0, 1)));
                put_record($urandom, $urandom, 8'h02, 34 + $urandom_range(0, 2), 1, 0, 1'b0);
            end
            else if (k < 78)
            begin
                fill_name(n, 1'b0);
                put_record($urandom, $urandom, 8'($urandom_range(0, 255)),
                           $urandom_range(1, (32 + n > 255) ? 255 : 32 + n), n, 0, 1'b0);
            end
            else if (k < 86)
                put_skip($urandom_range(0, 4) == 0);
            else if (k < 93)
                put_entry(n, 1'b1);
            else
            begin
                fill_name(n, 1'b0);
                put_record($urandom, $urandom, 8'($urandom_range(0, 255)),
                           (33 + n > 255) ? 255 : 33 + n, n, $urandom_range(1, 32 + n), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // idle mixes: none, sender gaps, receiver stalls, both
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(16);
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        run_random(16);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        run_random(16);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_random(16);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d directory bytes: %0d records, %0d sector skips, %0d extent ends.",
                 bytes_sent, records_sent, skips, extents_closed);
        $display("Compared %0d header and name chunk results, %0d mismatched.",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
